// ===== hw/rtl/brct_pkg.sv =====
// ----------------------------------------------------------------------------
// brct_pkg
// shared widths, codes and the control bundle broadcast to the segment cells
// ----------------------------------------------------------------------------
package brct_pkg;

	localparam int ADDR_W           = 48;
	localparam int LEN_W            = 31;
	localparam int MAX_SEGMENTS_DEF = 16;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic              find;
		logic              merge;
		logic              any_hit;
		logic              full;
		logic [ADDR_W-1:0] pos;
		logic [ADDR_W-1:0] newend;
	} ctl_t;

endpackage

// ===== hw/rtl/brct_cell.sv =====
// ----------------------------------------------------------------------------
// brct_cell
// one slot of the sorted segment row: compare, insert shift, absorb shift and
// running length sum handed to the right neighbor
// ----------------------------------------------------------------------------
module brct_cell #(
	parameter int SUM_W = 52
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brct_pkg::ctl_t               ctl,
	input  logic                         l_valid,
	input  logic                         l_gt,
	input  logic                         l_after,
	input  logic [brct_pkg::ADDR_W-1:0]  l_start,
	input  logic [brct_pkg::ADDR_W-1:0]  l_end,
	input  logic [SUM_W-1:0]             l_sum,
	input  logic                         r_valid,
	input  logic [brct_pkg::ADDR_W-1:0]  r_start,
	input  logic [brct_pkg::ADDR_W-1:0]  r_end,
	output logic                         valid,
	output logic                         gt,
	output logic                         hit,
	output logic                         ext,
	output logic                         after,
	output logic                         anchor,
	output logic                         cond,
	output logic [brct_pkg::ADDR_W-1:0]  seg_start,
	output logic [brct_pkg::ADDR_W-1:0]  seg_end,
	output logic [SUM_W-1:0]             sum
);
	import brct_pkg::*;

	logic              valid_q;
	logic              anchor_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] end_q;
	logic [SUM_W-1:0]  sum_q;
	logic              shift_in;
	logic              take_new;
	logic              do_insert;

	assign hit       = valid_q && (ctl.pos >= start_q) && (ctl.pos <= end_q);
	assign gt        = valid_q && (start_q > ctl.pos);
	assign ext       = hit && (ctl.newend > end_q);
	assign cond      = anchor_q && r_valid && (r_start <= end_q);
	assign after     = l_after | anchor_q;
	assign do_insert = ctl.find && !ctl.any_hit && !ctl.full;
	assign shift_in  = l_gt;
	assign take_new  = !l_gt && (gt || (!valid_q && l_valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			anchor_q <= 1'b0;
		end else if (ctl.find) begin
			if (ctl.any_hit) begin
				anchor_q <= ext;
			end else if (!ctl.full) begin
				anchor_q <= take_new;
				valid_q  <= valid_q | shift_in | take_new;
			end else begin
				anchor_q <= 1'b0;
			end
		end else if (ctl.merge && l_after) begin
			valid_q <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find && ctl.any_hit && ext) begin
			end_q <= ctl.newend;
		end else if (do_insert && shift_in) begin
			start_q <= l_start;
			end_q   <= l_end;
		end else if (do_insert && take_new) begin
			start_q <= ctl.pos;
			end_q   <= ctl.newend;
		end else if (ctl.merge && anchor_q) begin
			if (r_end > end_q) begin
				end_q <= r_end;
			end
		end else if (ctl.merge && l_after) begin
			start_q <= r_start;
			end_q   <= r_end;
		end
		sum_q <= l_sum + (valid_q ? SUM_W'(end_q - start_q) : '0);
	end

	assign valid     = valid_q;
	assign anchor    = anchor_q;
	assign seg_start = start_q;
	assign seg_end   = end_q;
	assign sum       = sum_q;

endmodule

// ===== hw/rtl/byte_range_coverage_tracker.sv =====
// ----------------------------------------------------------------------------
// byte_range_coverage_tracker
// sorted table of disjoint downloaded byte ranges held in a row of cells
// ----------------------------------------------------------------------------
// query: done rises after the look and output states
// record: done rises after the find, absorbing, sum, look and output states;
//   absorbing is skipped when a hit does not extend its segment or the table
//   is full; the length sum ripples through the cell row, one cell a cycle
// one item at a time; busy stays low from the cycle done is shown
// reset empties the table and clears coverage flag, resume position, file size
module byte_range_coverage_tracker #(
	parameter int MAX_SEGMENTS = brct_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [brct_pkg::ADDR_W-1:0]  position,
	input  logic [brct_pkg::LEN_W-1:0]   length,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [brct_pkg::ADDR_W-1:0]  cfg_data,
	output logic                         done,
	output logic                         in_segment,
	output logic                         enough_data,
	output logic [brct_pkg::ADDR_W-1:0]  segment_start,
	output logic [brct_pkg::ADDR_W-1:0]  segment_length,
	output logic                         all_covered,
	output logic [brct_pkg::ADDR_W-1:0]  resume_position,
	output logic                         table_full
);
	import brct_pkg::*;

	localparam int SUM_W = ADDR_W + $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_ABS  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_LOOK = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              op_q;
	logic [ADDR_W-1:0] pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] newend_q;
	logic              full_q;
	logic [ADDR_W-1:0] fsize_q;
	logic              done_flag_q;
	logic [ADDR_W-1:0] resume_q;
	logic              hit_q;
	logic [ADDR_W-1:0] hstart_q;
	logic [ADDR_W-1:0] hend_q;
	logic              strobe_q;
	logic              o_in_q;
	logic              o_enough_q;
	logic [ADDR_W-1:0] o_start_q;
	logic [ADDR_W-1:0] o_len_q;
	logic              o_full_q;

	logic [ADDR_W:0]   end_raw;
	logic [ADDR_W-1:0] end_sat;
	ctl_t              ctl;

	logic [MAX_SEGMENTS-1:0] c_valid, c_gt, c_hit, c_ext, c_after, c_anchor, c_cond;
	logic [ADDR_W-1:0]       c_start [MAX_SEGMENTS];
	logic [ADDR_W-1:0]       c_end   [MAX_SEGMENTS];
	logic [SUM_W-1:0]        c_sum   [MAX_SEGMENTS];

	logic              any_hit, any_ext, merge;
	logic [ADDR_W-1:0] sel_start, sel_end;

	assign end_raw = {1'b0, position} + (ADDR_W+1)'(length);
	assign end_sat = end_raw[ADDR_W] ? {ADDR_W{1'b1}} : end_raw[ADDR_W-1:0];

	assign any_hit = |c_hit;
	assign any_ext = |c_ext;
	assign merge   = |c_cond;

	always_comb begin
		sel_start = '0;
		sel_end   = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			sel_start = sel_start | (c_hit[i] ? c_start[i] : '0);
			sel_end   = sel_end   | (c_hit[i] ? c_end[i]   : '0);
		end
	end

	always_comb begin
		ctl.find    = (state_q == S_FIND);
		ctl.merge   = (state_q == S_ABS) && merge;
		ctl.any_hit = any_hit;
		ctl.full    = c_valid[MAX_SEGMENTS-1];
		ctl.pos     = pos_q;
		ctl.newend  = newend_q;
	end

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		logic              lv, lg, la;
		logic [ADDR_W-1:0] ls, le, rs, re;
		logic [SUM_W-1:0]  lsum;
		logic              rv;
		if (g == 0) begin : g_first
			assign lv   = 1'b1;
			assign lg   = 1'b0;
			assign la   = 1'b0;
			assign ls   = '0;
			assign le   = '0;
			assign lsum = '0;
		end else begin : g_mid
			assign lv   = c_valid[g-1];
			assign lg   = c_gt[g-1];
			assign la   = c_after[g-1];
			assign ls   = c_start[g-1];
			assign le   = c_end[g-1];
			assign lsum = c_sum[g-1];
		end
		if (g == MAX_SEGMENTS-1) begin : g_last
			assign rv = 1'b0;
			assign rs = '0;
			assign re = '0;
		end else begin : g_inner
			assign rv = c_valid[g+1];
			assign rs = c_start[g+1];
			assign re = c_end[g+1];
		end
		brct_cell #(.SUM_W(SUM_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.l_valid   (lv),
			.l_gt      (lg),
			.l_after   (la),
			.l_start   (ls),
			.l_end     (le),
			.l_sum     (lsum),
			.r_valid   (rv),
			.r_start   (rs),
			.r_end     (re),
			.valid     (c_valid[g]),
			.gt        (c_gt[g]),
			.hit       (c_hit[g]),
			.ext       (c_ext[g]),
			.after     (c_after[g]),
			.anchor    (c_anchor[g]),
			.cond      (c_cond[g]),
			.seg_start (c_start[g]),
			.seg_end   (c_end[g]),
			.sum       (c_sum[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			full_q      <= 1'b0;
			fsize_q     <= '0;
			done_flag_q <= 1'b0;
			resume_q    <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				fsize_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						full_q  <= 1'b0;
						state_q <= (operation == OP_QUERY) ? S_LOOK : S_FIND;
					end
				end
				S_FIND: begin
					cnt_q <= '0;
					if (any_hit) begin
						state_q <= any_ext ? S_ABS : S_SUM;
					end else if (c_valid[MAX_SEGMENTS-1]) begin
						full_q  <= 1'b1;
						state_q <= S_SUM;
					end else begin
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					if (!merge) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_SEGMENTS-1)) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (op_q == OP_RECORD) begin
						if (c_sum[MAX_SEGMENTS-1] >= SUM_W'(fsize_q)) begin
							done_flag_q <= 1'b1;
						end else if (c_valid[0] && (c_end[0] <= fsize_q)) begin
							resume_q <= c_end[0];
						end else begin
							resume_q <= fsize_q;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q     <= operation;
			pos_q    <= position;
			len_q    <= length;
			newend_q <= end_sat;
		end
		if (state_q == S_LOOK) begin
			hit_q    <= any_hit;
			hstart_q <= sel_start;
			hend_q   <= sel_end;
		end
		if (state_q == S_OUT) begin
			o_in_q     <= hit_q;
			o_enough_q <= hit_q && ((hend_q - pos_q) >= ADDR_W'(len_q));
			o_start_q  <= hit_q ? hstart_q : '0;
			o_len_q    <= hit_q ? (hend_q - hstart_q) : '0;
			o_full_q   <= full_q;
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = strobe_q;
	assign in_segment      = o_in_q;
	assign enough_data     = o_enough_q;
	assign segment_start   = o_start_q;
	assign segment_length  = o_len_q;
	assign all_covered     = done_flag_q;
	assign resume_position = resume_q;
	assign table_full      = o_full_q;

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid + 1'b1) & c_valid) == '0)
		else $error("segment cells not filled from the left");
	a_anchor_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ABS) |-> $onehot(c_anchor))
		else $error("absorb without a single anchor cell");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("item result shown while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("item result held more than one cycle");

endmodule
